// ----- sv/uartrx_pkg.sv -----
`timescale 1ns / 1ps

package uartrx_pkg;

    // field widths
    localparam int BIT_PERIOD_W  = 16;
    localparam int TICK_W        = 17;
    localparam int BIT_IDX_W     = 4;
    localparam int BYTE_W        = 8;
    localparam int FILL_W        = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int DATA_BITS     = 8;

    // defaults
    localparam int FIFO_DEPTH_DEF = 64;
    localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RST = 16'd104;

    // depth of the queue between receiver and fifo
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd1;

    // receiver phase
    typedef enum logic [1:0] {
        PH_HUNT,
        PH_DATA,
        PH_WAIT_HIGH
    } t_rx_phase;

    // one classified tick handed from receiver to fifo
    typedef struct packed {
        logic              take;
        logic              got;
        logic [BYTE_W-1:0] data;
    } t_q_item;

endpackage

// ----- sv/uartrx_front.sv -----
`timescale 1ns / 1ps

module uartrx_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [uartrx_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [uartrx_pkg::BIT_PERIOD_W-1:0]   i_cfg_data,
    input  logic                                  i_accept,
    input  logic                                  i_rx_level,
    input  logic                                  i_mode,
    output uartrx_pkg::t_q_item                   o_item
);
    import uartrx_pkg::*;

    logic [BIT_PERIOD_W-1:0] r_bit_period;
    logic                    r_enable;
    t_rx_phase               r_phase, n_phase;
    logic [TICK_W-1:0]       r_tick, n_tick;
    logic [BIT_IDX_W-1:0]    r_bit_idx, n_bit_idx;
    logic [BYTE_W-1:0]       r_shift, n_shift;

    logic [TICK_W-1:0]       target;
    logic [TICK_W-1:0]       tick_inc;
    logic [BIT_IDX_W-1:0]    bit_inc;
    logic [BYTE_W-1:0]       shift_new;
    logic                    sample;
    logic                    last_bit;
    logic                    got;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= BIT_PERIOD_RST;
            r_enable     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BIT_PERIOD: r_bit_period <= i_cfg_data;
                CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // bit timing: first sample at one and a half periods
    always_comb begin
        if (r_bit_idx == '0) begin
            target = {1'b0, r_bit_period} + {2'b0, r_bit_period[BIT_PERIOD_W-1:1]};
        end else begin
            target = {1'b0, r_bit_period};
        end
        tick_inc  = r_tick + 1'b1;
        bit_inc   = r_bit_idx + 1'b1;
        sample    = (tick_inc >= target);
        last_bit  = (bit_inc >= BIT_IDX_W'(DATA_BITS));
        shift_new = {i_rx_level, r_shift[BYTE_W-1:1]};
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_HUNT: begin
                if (r_enable && !i_rx_level) n_phase = PH_DATA;
            end
            PH_DATA: begin
                if (sample && last_bit) n_phase = i_rx_level ? PH_HUNT : PH_WAIT_HIGH;
            end
            PH_WAIT_HIGH: begin
                if (i_rx_level) n_phase = PH_HUNT;
            end
            default: n_phase = PH_HUNT;
        endcase
    end

    // datapath and outputs per phase
    always_comb begin
        n_tick    = r_tick;
        n_bit_idx = r_bit_idx;
        n_shift   = r_shift;
        got       = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                if (r_enable && !i_rx_level) begin
                    n_tick    = '0;
                    n_bit_idx = '0;
                    n_shift   = '0;
                end
            end
            PH_DATA: begin
                if (sample) begin
                    n_tick    = '0;
                    n_shift   = shift_new;
                    n_bit_idx = last_bit ? '0 : bit_inc;
                    got       = last_bit;
                end else begin
                    n_tick = tick_inc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_tick    <= '0;
            r_bit_idx <= '0;
            r_shift   <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_bit_idx <= n_bit_idx;
            r_shift   <= n_shift;
        end
    end

    // classified item for the fifo side
    assign o_item.take = i_mode;
    assign o_item.got  = got;
    assign o_item.data = shift_new;

endmodule

// ----- sv/uartrx_queue.sv -----
`timescale 1ns / 1ps

module uartrx_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  uartrx_pkg::t_q_item  i_item,
    input  logic                 i_pop,
    output uartrx_pkg::t_q_item  o_item,
    output logic                 o_full,
    output logic                 o_empty
);
    import uartrx_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    t_q_item          r_entry [QUEUE_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr;
    logic [QP_W-1:0]  r_rd_ptr;
    logic [QC_W-1:0]  r_count;

    assign o_full  = (r_count == QC_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_entry[r_rd_ptr];

    // entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_entry[r_wr_ptr] <= i_item;
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// ----- sv/uartrx_back.sv -----
`timescale 1ns / 1ps

module uartrx_back #(
    parameter int FIFO_DEPTH = uartrx_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  uartrx_pkg::t_q_item             i_item,
    input  logic                            i_q_empty,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [uartrx_pkg::BYTE_W-1:0]   o_read_byte,
    output logic                            o_read_valid,
    output logic [uartrx_pkg::BYTE_W-1:0]   o_front_byte,
    output logic                            o_front_valid,
    output logic [uartrx_pkg::FILL_W-1:0]   o_fill_count,
    output logic                            o_overflow_flag,
    output logic                            o_byte_received
);
    import uartrx_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int FW = (PW > FILL_W) ? PW : FILL_W;

    logic [BYTE_W-1:0] r_mem [FIFO_DEPTH];
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_count, n_count;
    logic [PW-1:0]     count_after_rd;
    logic              r_dropped;
    logic [BYTE_W-1:0] r_head;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_rd_byte;
    logic              r_rd_valid;
    logic              r_got;

    logic              step;
    logic              do_rd;
    logic              full;
    logic              do_wr;
    logic              head_bypass;
    logic [FW-1:0]     fill_ext;

    // take the next item when the result slot is free or being taken
    assign step  = !i_q_empty && (!r_out_valid || !i_stall);
    assign o_pop = step;

    // fifo update: read first, then the arriving byte
    always_comb begin
        do_rd          = i_item.take && (r_count != '0);
        count_after_rd = r_count - PW'(do_rd);
        n_rd_ptr       = r_rd_ptr;
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        full     = (count_after_rd == PW'(FIFO_DEPTH - 1));
        do_wr    = i_item.got && !full;
        n_wr_ptr = r_wr_ptr;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        n_count     = count_after_rd + PW'(do_wr);
        head_bypass = do_wr && (r_wr_ptr == n_rd_ptr);
    end

    // byte store and head read
    always_ff @(posedge i_clk) begin
        if (step) begin
            if (do_wr) r_mem[r_wr_ptr] <= i_item.data;
            r_head <= head_bypass ? i_item.data : r_mem[n_rd_ptr];
        end
    end

    // read result payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_rd_byte  <= do_rd ? r_head : '0;
            r_rd_valid <= do_rd;
            r_got      <= i_item.got;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_rd_ptr  <= n_rd_ptr;
                r_wr_ptr  <= n_wr_ptr;
                r_count   <= n_count;
                r_dropped <= r_dropped | (i_item.got && full);
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result fields
    assign fill_ext        = FW'(r_count);
    assign o_valid         = r_out_valid;
    assign o_read_byte     = r_rd_byte;
    assign o_read_valid    = r_rd_valid;
    assign o_front_valid   = (r_count != '0);
    assign o_front_byte    = o_front_valid ? r_head : '0;
    assign o_fill_count    = fill_ext[FILL_W-1:0];
    assign o_overflow_flag = r_dropped;
    assign o_byte_received = r_got;

endmodule

// ----- sv/uart_receiver_with_fifo.sv -----
`timescale 1ns / 1ps
// an accepted tick enters the queue, then its result is registered when the fifo side takes it
// throughput: one tick per cycle while nothing stalls; the fifo update has a registered head read
// a two-entry queue parts the receiver from the fifo, so each side stalls on its own
// reset: i_rst_n synchronous, active low; clears phase, counters, pointers and the overflow flag
// the byte store is not cleared and needs no clearing pass
module uart_receiver_with_fifo #(
    parameter int FIFO_DEPTH = uartrx_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_rx_level,
    input  logic                                i_mode,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [uartrx_pkg::BYTE_W-1:0]       o_read_byte,
    output logic                                o_read_valid,
    output logic [uartrx_pkg::BYTE_W-1:0]       o_front_byte,
    output logic                                o_front_valid,
    output logic [uartrx_pkg::FILL_W-1:0]       o_fill_count,
    output logic                                o_overflow_flag,
    output logic                                o_byte_received,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [uartrx_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [uartrx_pkg::BIT_PERIOD_W-1:0] i_cfg_data
);
    import uartrx_pkg::*;

    t_q_item front_item;
    t_q_item back_item;
    logic    accept;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    // receiver front
    uartrx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_rx_level  (i_rx_level),
        .i_mode      (i_mode),
        .o_item      (front_item)
    );

    // queue between front and fifo
    uartrx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (back_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // fifo back end
    uartrx_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (back_item),
        .i_q_empty       (q_empty),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_read_byte     (o_read_byte),
        .o_read_valid    (o_read_valid),
        .o_front_byte    (o_front_byte),
        .o_front_valid   (o_front_valid),
        .o_fill_count    (o_fill_count),
        .o_overflow_flag (o_overflow_flag),
        .o_byte_received (o_byte_received)
    );

    // queue never reports full and empty at once
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && q_empty))
        else $error("queue full and empty together");

    // a result appears only after the queue held an item
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!q_empty))
        else $error("result without queued item");

    // overflow flag is sticky
    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_overflow_flag |=> o_overflow_flag)
        else $error("overflow flag cleared");

    // an empty fifo never shows a front byte
    a_front_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_front_valid |-> (o_front_byte == '0))
        else $error("front byte without entry");

endmodule

// ----- verif/tb_uart_receiver_with_fifo.sv -----
`timescale 1ns / 1ps

module tb_uart_receiver_with_fifo;
    import uartrx_pkg::*;

    localparam int RX_DEPTH = FIFO_DEPTH_DEF;
    localparam int SHOW_MAX = 10;
    localparam int TICK_TARGET = 1750;

    // register indexes that the block has no register for
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // one result item per tick
    typedef struct {
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic [BYTE_W-1:0] front_byte;
        logic              front_valid;
        logic [FILL_W-1:0] fill_count;
        logic              overflow_flag;
        logic              byte_received;
    } t_rx_tick_result;

    // receiver and fifo predictor with the queue of expected tick results
    class uart_rx_scoreboard;
        logic [BIT_PERIOD_W-1:0] period_reg;
        logic                    enable_reg;
        t_rx_phase               phase;
        logic [TICK_W-1:0]       tick_cnt;
        logic [BIT_IDX_W-1:0]    bit_idx;
        logic [BYTE_W-1:0]       shreg;
        logic [BYTE_W-1:0]       bytes_held [RX_DEPTH];
        int                      wr_ptr;
        int                      rd_ptr;
        logic                    dropped;
        t_rx_tick_result         expected_ticks [$];
        int                      errors;

        function new();
            period_reg = BIT_PERIOD_RST;
            enable_reg = 1'b0;
            phase = PH_HUNT;
            tick_cnt = '0;
            bit_idx = '0;
            shreg = '0;
            foreach (bytes_held[i]) bytes_held[i] = '0;
            wr_ptr = 0;
            rd_ptr = 0;
            dropped = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BIT_PERIOD_W-1:0] data);
            if (idx == CFG_BIT_PERIOD)
                period_reg = data;
            else if (idx == CFG_ENABLE)
                enable_reg = data[0];
        endfunction

        function int ptr_next(int p);
            return (p + 1) % RX_DEPTH;
        endfunction

        // accepted tick: advance the predicted state and queue its result
        function void note_tick(logic lvl, logic take);
            t_rx_tick_result r;
            int target;
            int per;
            r = '{default: '0};
            per = period_reg;

            // a read sees the fifo as it was before the tick
            if (take && wr_ptr != rd_ptr) begin
                r.read_byte = bytes_held[rd_ptr];
                r.read_valid = 1'b1;
                rd_ptr = ptr_next(rd_ptr);
            end

            case (phase)
                PH_HUNT: begin
                    if (enable_reg && !lvl) begin
                        phase = PH_DATA;
                        tick_cnt = '0;
                        bit_idx = '0;
                        shreg = '0;
                    end
                end
                PH_DATA: begin
                    target = (bit_idx == 0) ? per + per / 2 : per;
                    tick_cnt = tick_cnt + 1'b1;
                    if (int'(tick_cnt) >= target) begin
                        tick_cnt = '0;
                        shreg = {lvl, shreg[BYTE_W-1:1]};
                        bit_idx = bit_idx + 1'b1;
                        if (bit_idx >= DATA_BITS) begin
                            r.byte_received = 1'b1;
                            bit_idx = '0;
                            if (ptr_next(wr_ptr) != rd_ptr) begin
                                bytes_held[wr_ptr] = shreg;
                                wr_ptr = ptr_next(wr_ptr);
                            end else begin
                                dropped = 1'b1;
                            end
                            phase = lvl ? PH_HUNT : PH_WAIT_HIGH;
                        end
                    end
                end
                default: begin
                    if (lvl)
                        phase = PH_HUNT;
                end
            endcase

            if (wr_ptr != rd_ptr) begin
                r.front_byte = bytes_held[rd_ptr];
                r.front_valid = 1'b1;
            end
            r.fill_count = FILL_W'((wr_ptr - rd_ptr + RX_DEPTH) % RX_DEPTH);
            r.overflow_flag = dropped;
            expected_ticks.push_back(r);
        endfunction

        function void check_tick_result(t_rx_tick_result act);
            t_rx_tick_result exp_r;
            if (expected_ticks.size() == 0) begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("%0t: result item with nothing expected", $realtime);
                return;
            end
            exp_r = expected_ticks.pop_front();
            if (act.read_byte !== exp_r.read_byte || act.read_valid !== exp_r.read_valid ||
                act.front_byte !== exp_r.front_byte ||
                act.front_valid !== exp_r.front_valid ||
                act.fill_count !== exp_r.fill_count ||
                act.overflow_flag !== exp_r.overflow_flag ||
                act.byte_received !== exp_r.byte_received) begin
                errors++;
                if (errors <= SHOW_MAX) begin
                    $display("%0t: mismatch rd %h/%b front %h/%b fill %0d ovf %b got %b",
                             $realtime, exp_r.read_byte, exp_r.read_valid, exp_r.front_byte,
                             exp_r.front_valid, exp_r.fill_count, exp_r.overflow_flag,
                             exp_r.byte_received);
                    $display("%0t:   actual rd %h/%b front %h/%b fill %0d ovf %b got %b",
                             $realtime, act.read_byte, act.read_valid, act.front_byte,
                             act.front_valid, act.fill_count, act.overflow_flag,
                             act.byte_received);
                end
            end
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        function void close_out();
            if (expected_ticks.size() != 0) begin
                errors++;
                $display("%0d result items never arrived", expected_ticks.size());
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_rx_level;
    logic                    i_mode;
    logic                    o_valid;
    logic                    i_stall;
    logic [BYTE_W-1:0]       o_read_byte;
    logic                    o_read_valid;
    logic [BYTE_W-1:0]       o_front_byte;
    logic                    o_front_valid;
    logic [FILL_W-1:0]       o_fill_count;
    logic                    o_overflow_flag;
    logic                    o_byte_received;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [BIT_PERIOD_W-1:0] i_cfg_data;

    uart_rx_scoreboard sb;
    int ticks_sent;
    int burst_left;
    int stall_pct;
    int stall_span;

    uart_receiver_with_fifo dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_level      (i_rx_level),
        .i_mode          (i_mode),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_read_byte     (o_read_byte),
        .o_read_valid    (o_read_valid),
        .o_front_byte    (o_front_byte),
        .o_front_valid   (o_front_valid),
        .o_fill_count    (o_fill_count),
        .o_overflow_flag (o_overflow_flag),
        .o_byte_received (o_byte_received),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver stall pattern, its density is redrawn whenever the stall_span count runs out
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            case ($urandom_range(0, 4))
                0, 1: stall_pct <= 0;
                2: stall_pct <= 30;
                3: stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
            stall_span <= $urandom_range(20, 80);
        end else begin
            stall_span <= stall_span - 1;
        end
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // result items are checked as they are taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_tick_result('{o_read_byte, o_read_valid, o_front_byte, o_front_valid,
                                   o_fill_count, o_overflow_flag, o_byte_received});
    end

    function automatic logic roll(int pct);
        return ($urandom_range(0, 99) < pct);
    endfunction

    // one line tick, sent in bursts with random gaps
    task automatic send_tick(input logic lvl, input logic take);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_rx_level <= lvl;
        i_mode <= take;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_tick(lvl, take);
        ticks_sent++;
    endtask

    // hold off the sender until every expected result item is in
    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [BIT_PERIOD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // a well-formed 8n1 frame at the current bit period, lsb first
    task automatic send_frame(input logic [7:0] data, input int read_pct,
                              input bit read_last, input int stop_ticks);
        int per;
        int n;
        per = sb.period_reg;
        send_tick(1'b0, roll(read_pct));
        for (int i = 0; i < DATA_BITS; i++) begin
            n = (i == 0) ? per + per / 2 : per;
            if (n < 1)
                n = 1;
            for (int k = 0; k < n; k++)
                send_tick(data[i], (read_last && i == DATA_BITS - 1 && k == n - 1) ?
                          1'b1 : roll(read_pct));
        end
        // a low last bit needs the line high again before the next start
        if (!data[7] && stop_ticks < 1)
            stop_ticks = 1;
        repeat (stop_ticks) send_tick(1'b1, roll(read_pct));
    endtask

    task automatic send_noise(input int n, input int read_pct);
        repeat (n) send_tick(1'($urandom_range(0, 1)), roll(read_pct));
    endtask

    // random frames with some noise and cut-off frames in between
    task automatic run_frames(input int n_frames, input int read_pct);
        int cut;
        repeat (n_frames) begin
            if (roll(10))
                send_noise($urandom_range(1, 8), read_pct);
            if (roll(5)) begin
                cut = $urandom_range(1, 8 * (sb.period_reg + 2));
                send_tick(1'b0, roll(read_pct));
                send_noise(cut, read_pct);
                send_frame(8'hff, read_pct, 1'b0, 1);
            end else begin
                send_frame(8'($urandom_range(0, 255)), read_pct, roll(20),
                           $urandom_range(0, 3));
            end
        end
    endtask

    initial begin
        int per;
        int read_pct;
        sb = new();
        ticks_sent = 0;
        burst_left = 0;
        stall_pct = 0;
        stall_span = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_rx_level = 1'b1;
        i_mode = 1'b0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // disabled after reset: a low line starts nothing, reads on empty fifo
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        wait_drain();

        // writes to indexes with no register are ignored
        write_cfg(CFG_SPARE_A, 16'hffff);
        write_cfg(CFG_SPARE_B, 16'h0000);
        write_cfg(CFG_BIT_PERIOD, 16'd1);
        write_cfg(CFG_ENABLE, 16'd1);

        // low last bit waits for high, then read and arrival on one tick
        send_frame(8'h00, 0, 1'b0, 1);
        send_frame(8'hff, 0, 1'b1, 0);
        send_frame(8'ha5, 0, 1'b1, 1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        wait_drain();

        // enable dropped mid-frame: the frame still completes
        write_cfg(CFG_BIT_PERIOD, 16'd2);
        send_tick(1'b0, 1'b0);
        send_noise(3, 0);
        wait_drain();
        write_cfg(CFG_ENABLE, 16'd0);
        send_noise(16, 20);
        repeat (3) send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        wait_drain();

        // longest bit period, then cut short with the count already past it
        write_cfg(CFG_ENABLE, 16'd1);
        write_cfg(CFG_BIT_PERIOD, 16'hffff);
        send_tick(1'b0, 1'b0);
        send_noise(20, 10);
        wait_drain();
        write_cfg(CFG_BIT_PERIOD, 16'd2);
        send_noise(20, 10);
        repeat (3) send_tick(1'b1, 1'b0);
        wait_drain();

        // fill the fifo past full with no reads, then free room on an arrival
        write_cfg(CFG_BIT_PERIOD, 16'd0);
        repeat (66) send_frame(8'($urandom_range(0, 255)), 0, 1'b0, 1);
        send_frame(8'($urandom_range(0, 255)), 0, 1'b1, 1);
        wait_drain();

        // drain with frequent reads at a bit period of 2
        write_cfg(CFG_BIT_PERIOD, 16'd2);
        run_frames(4, 90);
        wait_drain();

        // random settings and read densities
        while (ticks_sent < TICK_TARGET) begin
            case ($urandom_range(0, 9))
                0: per = $urandom_range(0, 1);
                1, 2, 3, 4, 5, 6: per = $urandom_range(2, 6);
                7, 8: per = $urandom_range(7, 16);
                default: per = $urandom_range(17, 40);
            endcase
            case ($urandom_range(0, 4))
                0: read_pct = 0;
                1: read_pct = 5;
                2: read_pct = 20;
                3: read_pct = 50;
                default: read_pct = 90;
            endcase
            write_cfg(CFG_BIT_PERIOD, BIT_PERIOD_W'(per));
            write_cfg(CFG_ENABLE, roll(90) ? 16'd1 : 16'd0);
            run_frames($urandom_range(2, 8), read_pct);
            wait_drain();
        end

        wait_drain();
        repeat (10) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("tb_uart_receiver_with_fifo: done, clean");
        else
            $display("tb_uart_receiver_with_fifo: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("tb_uart_receiver_with_fifo: done, errors");
        $finish;
    end

endmodule
